>>> rtl/fibc_pkg.sv
// ----------------------------------------------------------------------------
// fibc_pkg: shared types and constants for the flux interval decoder
// Field widths, register indexes, sequencer states and the interface structs
// between the top level and the rounding divider.
// ----------------------------------------------------------------------------
package fibc_pkg;

    localparam int CT_W      = 16;   // cell time and threshold registers
    localparam int INT_W     = 24;   // flux interval
    localparam int ACC_W     = 27;   // signed working width for sum and error
    localparam int CARRY_W   = 18;   // carried error state
    localparam int RES_W     = 17;   // reported residual error
    localparam int PEAK_W    = 25;   // peak error magnitude
    localparam int CNT_W     = 32;   // saturating counters
    localparam int CELLS_W   = 4;
    localparam int PAT_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 24;
    localparam int M_FIELD_W = CELLS_W + PAT_W + RES_W + PEAK_W + 3 * CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CELLS_W-1:0] MAX_CELLS = 4'd8;
    localparam logic [CT_W-1:0]    CT_RESET  = 16'd32000;
    localparam logic [CT_W-1:0]    THR_RESET = 16'd3200;
    localparam logic [CNT_W-1:0]   CNT_SAT   = {CNT_W{1'b1}};
    localparam logic [PAT_W-1:0]   PAT_FIRST = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_TIME  = 1'b0,
        CFG_ERR_THRESH = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CONVERT,
        OP_IGNORE,
        OP_CLEAR
    } op_kind_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_WAIT,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_FIRST,
        DIV_STEP
    } div_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] sum;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [CELLS_W-1:0]      cells;
        logic signed [ACC_W-1:0] err;
    } div_rsp_t;

endpackage

>>> rtl/fibc_round_div.sv
// ----------------------------------------------------------------------------
// fibc_round_div: rounding cell count by repeated subtraction
// One shared subtractor always removes a first cell time, then one per cycle
// while twice the remainder still reaches the cell time, up to the cell limit.
// ----------------------------------------------------------------------------
module fibc_round_div
    import fibc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  div_req_t        req,
    input  logic [CT_W-1:0] cell_time,
    output div_rsp_t        rsp
);

    div_state_t              state_reg, state_next;
    logic signed [ACC_W-1:0] r_reg, r_next;
    logic [CELLS_W-1:0]      cells_reg, cells_next;
    logic                    pos_reg, pos_next;
    logic                    done_reg, done_next;

    logic signed [ACC_W-1:0] ct_ext;
    logic signed [ACC_W:0]   ct_ext2;
    logic signed [ACC_W:0]   r_twice;
    logic signed [ACC_W-1:0] diff;
    logic                    step_ok;

    assign ct_ext  = $signed({{(ACC_W - CT_W){1'b0}}, cell_time});
    assign ct_ext2 = $signed({{(ACC_W + 1 - CT_W){1'b0}}, cell_time});
    assign r_twice = $signed({r_reg, 1'b0});
    // shared subtractor
    assign diff    = r_reg - ct_ext;
    assign step_ok = (cells_reg < MAX_CELLS) && (r_twice >= ct_ext2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            cells_reg <= '0;
            pos_reg   <= 1'b0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cells_reg <= cells_next;
            pos_reg   <= pos_next;
            r_reg     <= r_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cells_next = cells_reg;
        pos_next   = pos_reg;
        r_next     = r_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    r_next     = req.sum;
                    pos_next   = (req.sum > 0);
                    state_next = DIV_FIRST;
                end
            end
            DIV_FIRST:
            begin
                // one cell always; a sum at or below zero stops here
                r_next     = diff;
                cells_next = {{(CELLS_W - 1){1'b0}}, 1'b1};
                if (pos_reg)
                begin
                    state_next = DIV_STEP;
                end
                else
                begin
                    state_next = DIV_IDLE;
                    done_next  = 1'b1;
                end
            end
            DIV_STEP:
            begin
                if (step_ok)
                begin
                    r_next     = diff;
                    cells_next = cells_reg + 1'b1;
                end
                else
                begin
                    state_next = DIV_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.cells = cells_reg;
    assign rsp.err   = r_reg;

    a_cells_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cells_reg <= MAX_CELLS)
        else $error("cell count beyond limit");

    a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (cells_reg != '0) && (state_reg == DIV_IDLE))
        else $error("divider finished without a cell");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_IDLE) && req.start |=> (state_reg == DIV_FIRST))
        else $error("divider missed a start");

endmodule

>>> rtl/flux_interval_to_bit_cells_top.sv
// ----------------------------------------------------------------------------
// flux_interval_to_bit_cells_top: flux interval to bit cell decoder
// Rounds each flux interval plus carried error to a cell count, tracks and
// snaps the timing error, and reports the cells with running statistics.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                          | tuser
//  s_*      | in  | interval[23:0]                                 | func
//  m_*      | out | cell_count, bit_pattern, residual_error,       | snapped
//           |     | peak_error, pulses_seen, cells_emitted,        |
//           |     | snap_count (lowest bits first, 2 pad bits)     |
//  cfg_*    | in  | cfg_index 0 cell_time, 1 snap threshold        | -
//
//  A conversion with a positive sum passes from acceptance through the
//  divider's first-cell and step states, then the wait and emit states, to
//  the output register; a sum at or below zero skips the step states.
//  Clear and zero interval words skip the divider and load from the emit state.
//  s_tready is high only between words, from the cycle after the output
//  register loads; the load waits while the previous result sits on m_tready.
//  Reset restores the register defaults and clears error and counters.
// ----------------------------------------------------------------------------
module flux_interval_to_bit_cells_top
    import fibc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // interval[23:0]
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_count[3:0], bit_pattern[11:4], residual_error[28:12],
    // peak_error[53:29], pulses_seen[85:54], cells_emitted[117:86],
    // snap_count[149:118]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,   // snapped
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CT_W-1:0]       cfg_data
);

    top_state_t               state_reg, state_next;
    op_kind_t                 kind_reg, kind_next;
    logic [CT_W-1:0]          cell_time_reg;
    logic [CT_W-1:0]          thresh_reg;
    logic signed [CARRY_W-1:0] carry_reg, carry_next;
    logic [PEAK_W-1:0]        worst_reg, worst_next;
    logic [CNT_W-1:0]         pulse_reg, pulse_next;
    logic [CNT_W-1:0]         cellcnt_reg, cellcnt_next;
    logic [CNT_W-1:0]         snapcnt_reg, snapcnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;
    logic                     out_user_reg, out_user_next;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     accept;
    logic                     emit;
    logic signed [ACC_W-1:0]  sum;
    logic [ACC_W-1:0]         mag_full;
    logic [PEAK_W-1:0]        mag;
    logic                     snap;
    logic [CELLS_W-1:0]       o_cells;
    logic [PAT_W-1:0]         o_pattern;
    logic [CNT_W:0]           cell_sum;

    assign s_tready = (state_reg == TOP_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == TOP_EMIT) && (!out_valid_reg || m_tready);

    assign sum = $signed({{(ACC_W - INT_W){1'b0}}, s_tdata[INT_W-1:0]})
               + $signed({{(ACC_W - CARRY_W){carry_reg[CARRY_W-1]}}, carry_reg});

    assign div_req.start = accept && !s_tuser && (s_tdata[INT_W-1:0] != '0);
    assign div_req.sum   = sum;

    fibc_round_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .cell_time (cell_time_reg),
        .rsp       (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        kind_next  = OP_CLEAR;
                        state_next = TOP_EMIT;
                    end
                    else if (s_tdata[INT_W-1:0] == '0)
                    begin
                        kind_next  = OP_IGNORE;
                        state_next = TOP_EMIT;
                    end
                    else
                    begin
                        kind_next  = OP_CONVERT;
                        state_next = TOP_WAIT;
                    end
                end
            end
            TOP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = TOP_EMIT;
                end
            end
            TOP_EMIT:
            begin
                if (emit)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    // error tracking and result word
    assign mag_full = div_rsp.err[ACC_W-1] ? ACC_W'(-div_rsp.err) : div_rsp.err;
    assign mag      = mag_full[PEAK_W-1:0];
    assign snap     = (mag > {{(PEAK_W - CT_W){1'b0}}, thresh_reg});
    assign cell_sum = {1'b0, cellcnt_reg} + {{(CNT_W + 1 - CELLS_W){1'b0}}, div_rsp.cells};

    always_comb
    begin
        carry_next    = carry_reg;
        worst_next    = worst_reg;
        pulse_next    = pulse_reg;
        cellcnt_next  = cellcnt_reg;
        snapcnt_next  = snapcnt_reg;
        o_cells       = '0;
        o_pattern     = '0;
        out_user_next = 1'b0;
        case (kind_reg)
            OP_CLEAR:
            begin
                carry_next   = '0;
                worst_next   = '0;
                pulse_next   = '0;
                cellcnt_next = '0;
                snapcnt_next = '0;
            end
            OP_CONVERT:
            begin
                o_cells   = div_rsp.cells;
                o_pattern = PAT_FIRST >> (div_rsp.cells - 1'b1);
                if (mag > worst_reg)
                begin
                    worst_next = mag;
                end
                if (snap)
                begin
                    carry_next    = '0;
                    out_user_next = 1'b1;
                    if (snapcnt_reg != CNT_SAT)
                    begin
                        snapcnt_next = snapcnt_reg + 1'b1;
                    end
                end
                else
                begin
                    carry_next = div_rsp.err[CARRY_W-1:0];
                end
                if (pulse_reg != CNT_SAT)
                begin
                    pulse_next = pulse_reg + 1'b1;
                end
                cellcnt_next = cell_sum[CNT_W] ? CNT_SAT : cell_sum[CNT_W-1:0];
            end
            default:
            begin
                // zero interval: report the current state unchanged
            end
        endcase
        out_data_next = {{(M_TDATA_W - M_FIELD_W){1'b0}}, snapcnt_next, cellcnt_next,
                         pulse_next, worst_next, carry_next[RES_W-1:0],
                         o_pattern, o_cells};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            kind_reg      <= OP_IGNORE;
            cell_time_reg <= CT_RESET;
            thresh_reg    <= THR_RESET;
            carry_reg     <= '0;
            worst_reg     <= '0;
            pulse_reg     <= '0;
            cellcnt_reg   <= '0;
            snapcnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                carry_reg   <= carry_next;
                worst_reg   <= worst_next;
                pulse_reg   <= pulse_next;
                cellcnt_reg <= cellcnt_next;
                snapcnt_reg <= snapcnt_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CELL_TIME:  cell_time_reg <= cfg_data;
                    CFG_ERR_THRESH: thresh_reg    <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // output payload holds until a new word is loaded
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while a word is in progress");

    a_pattern_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[3:0] == '0) == (m_tdata[11:4] == '0)))
        else $error("bit pattern disagrees with cell count");

    a_pattern_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] != '0) |-> $onehot(m_tdata[11:4]))
        else $error("bit pattern is not a single cell mark");

    a_snap_zeroes_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[28:12] == '0))
        else $error("snapped word carries residual error");

endmodule
